[hdl/oal_pkg.sv]
package oal_pkg;

  // Largest number of entries the list holds (2 to 64).
  localparam int LIST_CAPACITY = 64;
  localparam int ADDR_W        = $clog2(LIST_CAPACITY);

  // Operation codes
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_FIND   = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_PURGE  = 3'd4;
  localparam logic [2:0] KIND_CLEAR  = 3'd5;

  // Status codes
  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_BADPOS = 3'd2;
  localparam logic [2:0] ST_NOKEY  = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        payload;
    logic               flag;
  } entry_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         index;
    logic signed [31:0] key;
    logic [63:0]        payload;
    logic               flag;
    logic [6:0]         count;
    logic               last;
  } result_t;

  // Single closing result with no entry attached.
  function automatic result_t bare_result(input logic [2:0] st, input logic [6:0] cnt);
    result_t r;
    r         = '0;
    r.status  = st;
    r.count   = cnt;
    r.last    = 1'b1;
    return r;
  endfunction

endpackage

[hdl/ordered_array_list_engine_core.sv]
// Ordered list engine: a packed list of up to LIST_CAPACITY entries (key, payload,
// keep flag) held in one synchronous RAM with one write and one read port.
// Input channel: in_valid / in_stall carry one operation item (kind, position,
// key, payload, keep_flag). in_stall is high while an operation is in progress.
// Output channel: out_valid / out_stall carry result items; last marks the final
// result of an operation. Purge sends one item per removed entry (one if none is removed), all others one.
// Insert walks from the end down to the position (no walk when appending), delete
// from the position to the end, read takes one entry, find walks until its first
// match and purge walks the whole list; clear and failed requests go straight to
// their result. The walk reads one entry per cycle through the RAM read port
// (a purge may pause it, see below) and writes the moved entry back through the
// write port from the registered read data.
// A new item is taken once the previous operation has loaded its last result
// into the output register, even if that result is still waiting to be taken.
// Reset clears the entry count and the handshake state; the RAM is not cleared,
// entries are only read after they were written.
// When the receiver stalls, the result holds in the output register; a purge
// pauses its walk while a removed entry waits for the output register.
module ordered_array_list_engine_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            kind,
  input  logic [6:0]            position,
  input  logic signed [31:0]    key,
  input  logic [63:0]           payload,
  input  logic                  keep_flag,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [5:0]            index_out,
  output logic signed [31:0]    key_out,
  output logic [63:0]           payload_out,
  output logic                  flag_out,
  output logic [6:0]            count,
  output logic                  last
);

  import oal_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_RESP} state_t;

  state_t state;

  // captured operation
  logic [2:0]          op_kind;
  logic [6:0]          op_pos;
  logic signed [31:0]  op_key;
  logic [63:0]         op_payload;
  logic                op_flag;

  // list bookkeeping and walk pointers
  logic [6:0]          ent_count;
  logic [6:0]          rd_ptr;
  logic [6:0]          rd_end;
  logic [6:0]          wr_ptr;
  logic [6:0]          rm_cnt;
  logic                rd_pend;
  logic [ADDR_W-1:0]   rd_addr_q;

  // pending result (for purge: the removed entry held back until the next one is known)
  result_t             res;
  logic                held;

  // output register
  result_t             out_q;
  logic                out_valid_q;

  // entry RAM
  entry_t              mem [LIST_CAPACITY];
  entry_t              rdata;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  entry_t              mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;

  // walk control
  logic                out_free;
  logic                out_load;
  logic                descend;
  logic                can_issue;
  logic                rem_hit;
  logic                scan_hold;
  logic                find_hit;
  logic                scan_done;
  logic                issue;
  logic [6:0]          rd_prev;

  assign in_stall    = (state != S_IDLE);
  assign out_valid   = out_valid_q;
  assign status      = out_q.status;
  assign index_out   = out_q.index;
  assign key_out     = out_q.key;
  assign payload_out = out_q.payload;
  assign flag_out    = out_q.flag;
  assign count       = out_q.count;
  assign last        = out_q.last;

  always_comb begin
    out_free  = !out_valid_q || !out_stall;
    // insert moves entries up, so it walks from the top down
    descend   = (op_kind == KIND_INSERT);
    rd_prev   = rd_ptr - 7'd1;
    can_issue = descend ? (rd_ptr > op_pos) : (rd_ptr < rd_end);
    rem_hit   = rd_pend && (op_kind == KIND_PURGE) && !rdata.flag;
    // hold the walk while a second removed entry has nowhere to go
    scan_hold = rem_hit && held && !out_free;
    find_hit  = rd_pend && (op_kind == KIND_FIND) && (rdata.key == op_key);
    scan_done = !rd_pend && !can_issue;
    issue     = (state == S_RUN) && can_issue && !scan_hold && !find_hit;
    // load the output register with the closing result, or with a held purge
    // result once a later removal shows it is not the last
    out_load  = ((state == S_RESP) && out_free) ||
                ((state == S_RUN) && rem_hit && held && !scan_hold);

    mem_re    = issue;
    mem_raddr = descend ? rd_prev[ADDR_W-1:0] : rd_ptr[ADDR_W-1:0];

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata;
    if (state == S_RUN) begin
      if (rd_pend && !scan_hold) begin
        case (op_kind)
          KIND_INSERT: begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_q + ADDR_W'(1);
          end
          KIND_DELETE: begin
            if (rd_addr_q != op_pos[ADDR_W-1:0]) begin
              mem_we    = 1'b1;
              mem_waddr = rd_addr_q - ADDR_W'(1);
            end
          end
          KIND_PURGE: begin
            if (rdata.flag) begin
              mem_we    = 1'b1;
              mem_waddr = wr_ptr[ADDR_W-1:0];
            end
          end
          default: ;
        endcase
      end else if (scan_done && (op_kind == KIND_INSERT)) begin
        // gap is open: drop the new entry in
        mem_we            = 1'b1;
        mem_waddr         = op_pos[ADDR_W-1:0];
        mem_wdata.key     = op_key;
        mem_wdata.payload = op_payload;
        mem_wdata.flag    = op_flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_q <= 1'b0;
      ent_count   <= '0;
      rd_pend     <= 1'b0;
      held        <= 1'b0;
    end else begin
      if (out_load) begin
        out_q       <= res;
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_kind    <= kind;
            op_pos     <= position;
            op_key     <= key;
            op_payload <= payload;
            op_flag    <= keep_flag;
            rd_pend    <= 1'b0;
            held       <= 1'b0;
            wr_ptr     <= '0;
            rm_cnt     <= '0;
            unique case (kind) inside
              KIND_INSERT: begin
                if (ent_count >= 7'(LIST_CAPACITY)) begin
                  res   <= bare_result(ST_FULL, ent_count);
                  state <= S_RESP;
                end else if (position > ent_count) begin
                  res   <= bare_result(ST_BADPOS, ent_count);
                  state <= S_RESP;
                end else begin
                  rd_ptr <= ent_count;
                  state  <= S_RUN;
                end
              end
              KIND_DELETE, KIND_READ: begin
                if (ent_count == 7'd0) begin
                  res   <= bare_result(ST_EMPTY, ent_count);
                  state <= S_RESP;
                end else if (position >= ent_count) begin
                  res   <= bare_result(ST_BADPOS, ent_count);
                  state <= S_RESP;
                end else begin
                  rd_ptr <= position;
                  rd_end <= (kind == KIND_READ) ? position + 7'd1 : ent_count;
                  state  <= S_RUN;
                end
              end
              KIND_FIND, KIND_PURGE: begin
                if (ent_count == 7'd0) begin
                  res   <= bare_result(ST_EMPTY, ent_count);
                  state <= S_RESP;
                end else begin
                  rd_ptr <= '0;
                  rd_end <= ent_count;
                  state  <= S_RUN;
                end
              end
              KIND_CLEAR: begin
                ent_count <= '0;
                res       <= bare_result(ST_DONE, 7'd0);
                state     <= S_RESP;
              end
              default: ;
            endcase
          end
        end

        S_RUN: begin
          // advance the read side
          if (issue) begin
            rd_ptr    <= descend ? rd_prev : rd_ptr + 7'd1;
            rd_addr_q <= mem_raddr;
            rd_pend   <= 1'b1;
          end else if (!scan_hold) begin
            rd_pend <= 1'b0;
          end

          // retire the entry held in the read data register
          if (rd_pend && !scan_hold) begin
            unique case (op_kind) inside
              KIND_DELETE, KIND_READ: begin
                if (rd_addr_q == op_pos[ADDR_W-1:0]) begin
                  res.key     <= rdata.key;
                  res.payload <= rdata.payload;
                  res.flag    <= rdata.flag;
                end
              end
              KIND_FIND: begin
                if (find_hit) begin
                  res.status  <= ST_DONE;
                  res.index   <= 6'(rd_addr_q);
                  res.key     <= rdata.key;
                  res.payload <= rdata.payload;
                  res.flag    <= rdata.flag;
                  res.count   <= ent_count;
                  res.last    <= 1'b1;
                  state       <= S_RESP;
                end
              end
              KIND_PURGE: begin
                if (rdata.flag) begin
                  wr_ptr <= wr_ptr + 7'd1;
                end else begin
                  // a later removal exists, so the held one goes out now
                  res.status  <= ST_DONE;
                  res.index   <= wr_ptr[5:0];
                  res.key     <= rdata.key;
                  res.payload <= rdata.payload;
                  res.flag    <= 1'b0;
                  res.count   <= ent_count - rm_cnt - 7'd1;
                  res.last    <= 1'b0;
                  held        <= 1'b1;
                  rm_cnt      <= rm_cnt + 7'd1;
                end
              end
              default: ;
            endcase
          end else if (scan_done) begin
            unique case (op_kind) inside
              KIND_INSERT: begin
                ent_count   <= ent_count + 7'd1;
                res.status  <= ST_DONE;
                res.index   <= op_pos[5:0];
                res.key     <= op_key;
                res.payload <= op_payload;
                res.flag    <= op_flag;
                res.count   <= ent_count + 7'd1;
                res.last    <= 1'b1;
              end
              KIND_DELETE: begin
                ent_count  <= ent_count - 7'd1;
                res.status <= ST_DONE;
                res.index  <= op_pos[5:0];
                res.count  <= ent_count - 7'd1;
                res.last   <= 1'b1;
              end
              KIND_READ: begin
                res.status <= ST_DONE;
                res.index  <= op_pos[5:0];
                res.count  <= ent_count;
                res.last   <= 1'b1;
              end
              KIND_FIND: begin
                res <= bare_result(ST_NOKEY, ent_count);
              end
              KIND_PURGE: begin
                ent_count <= wr_ptr;
                if (held) res.last <= 1'b1;
                else      res      <= bare_result(ST_DONE, ent_count);
              end
              default: ;
            endcase
            state <= S_RESP;
          end
        end

        S_RESP: begin
          if (out_free) state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // The list never grows past its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ent_count <= 7'(LIST_CAPACITY))
    else $error("entry count above capacity");

  // The RAM is only written while an operation walks the list.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("RAM write while idle");

  // A result that is not final can only be waiting during a purge.
  a_mid_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid_q && !out_q.last) |-> (state == S_RUN || state == S_RESP))
    else $error("non-final result left outside an operation");

endmodule
